[rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache engine.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam logic [15:0] MIN_FRAME  = 16'd28;
	localparam logic [15:0] HTYPE_ETH  = 16'd1;
	localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  HLEN_ETH   = 8'd6;
	localparam logic [7:0]  PLEN_IPV4  = 8'd4;
	localparam logic [15:0] OP_REQUEST = 16'd1;

	localparam logic ACT_PACKET  = 1'b0;
	localparam logic ACT_RESOLVE = 1'b1;

	localparam logic [0:0] REG_LOCAL_IP  = 1'b0;
	localparam logic [0:0] REG_LOCAL_MAC = 1'b1;

	typedef enum logic [2:0] {
		ST_RESOLVED = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_PENDING  = 3'd2,
		ST_FAILED   = 3'd3,
		ST_DROPPED  = 3'd4,
		ST_ACCEPTED = 3'd5,
		ST_FULL     = 3'd6
	} status_t;

	typedef struct packed {
		logic        action;
		logic [15:0] frame_bytes;
		logic [15:0] hw_type;
		logic [15:0] ptype;
		logic [7:0]  hw_len;
		logic [7:0]  plen;
		logic [15:0] opcode;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] target_ip;
		logic        has_payload;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] mac_out;
		logic [31:0] ip_out;
		logic        send_request;
		logic        send_reply;
		logic        release_held;
	} rsp_t;

	// Table entry as stored in memory
	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic        pending;
	} entry_t;

	// Memory access bundle from controller to table
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

[rtl/arpc_table.sv]
// ----------------------------------------------------------------------------
// arpc_table
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_table
	import arpc_pkg::*;
(
	input  logic     clk,
	input  mem_req_t mreq,
	output entry_t   rd_data
);

	entry_t mem_q [TABLE_DEPTH];

	// Write and read the entry store
	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem_q[mreq.wr_addr] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			rd_data <= mem_q[mreq.rd_addr];
		end
	end

endmodule

[rtl/arpc_ctrl.sv]
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: scans the table newest first, then updates or inserts.
// ----------------------------------------------------------------------------
module arpc_ctrl
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  req_t        req,
	input  logic [31:0] local_ip,
	output logic        busy,
	output logic        done,
	output rsp_t        result,
	output mem_req_t    mreq,
	input  entry_t      rd_data
);

	state_t           state_q, state_d;
	req_t             req_q;
	logic [CNT_W-1:0] used_q, used_d;
	logic [CNT_W-1:0] scan_q, scan_d;   // entries still to look at
	logic [IDX_W-1:0] addr_q, addr_d;   // address read last cycle
	logic             rd_vld_q, rd_vld_d;
	logic             hit_q, hit_d;
	logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
	logic             hit_pend_q, hit_pend_d;
	logic [47:0]      hit_mac_q, hit_mac_d;
	rsp_t             res_q, res_d;
	logic             done_q, done_d;
	logic [31:0]      key;
	logic             hdr_ok;
	logic             full;
	logic             found;

	assign key    = (req_q.action == ACT_RESOLVE) ? req_q.target_ip : req_q.sender_ip;
	assign hdr_ok = (req_q.frame_bytes >= MIN_FRAME) && (req_q.hw_type == HTYPE_ETH)
		&& (req_q.ptype == PTYPE_IPV4) && (req_q.hw_len == HLEN_ETH)
		&& (req_q.plen == PLEN_IPV4);
	assign full   = (used_q == CNT_W'(TABLE_DEPTH));
	assign found  = rd_vld_q && (rd_data.ip == key);

	// Hold state and capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			done_q   <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			used_q   <= used_d;
			done_q   <= done_d;
			rd_vld_q <= rd_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		scan_q     <= scan_d;
		addr_q     <= addr_d;
		hit_q      <= hit_d;
		hit_idx_q  <= hit_idx_d;
		hit_pend_q <= hit_pend_d;
		hit_mac_q  <= hit_mac_d;
		res_q      <= res_d;
	end

	// Advance the scan and build the result
	always_comb begin
		state_d    = state_q;
		used_d     = used_q;
		scan_d     = scan_q;
		addr_d     = addr_q;
		rd_vld_d   = 1'b0;
		hit_d      = hit_q;
		hit_idx_d  = hit_idx_q;
		hit_pend_d = hit_pend_q;
		hit_mac_d  = hit_mac_q;
		res_d      = res_q;
		done_d     = 1'b0;
		mreq       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
					scan_d  = used_q;
					hit_d   = 1'b0;
				end
			end
			S_SCAN: begin
				if (req_q.action == ACT_PACKET && !hdr_ok) begin
					state_d = S_CHECK;
				end else if (found) begin
					hit_d      = 1'b1;
					hit_idx_d  = addr_q;
					hit_pend_d = rd_data.pending;
					hit_mac_d  = rd_data.mac;
					state_d    = S_CHECK;
				end else if (scan_q == '0) begin
					state_d = S_CHECK;
				end else begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = IDX_W'(scan_q - CNT_W'(1));
					addr_d       = IDX_W'(scan_q - CNT_W'(1));
					scan_d       = scan_q - CNT_W'(1);
					rd_vld_d     = 1'b1;
				end
			end
			S_CHECK: begin
				res_d   = '0;
				state_d = S_DONE;
				done_d  = 1'b1;
				if (req_q.action == ACT_RESOLVE) begin
					if (hit_q) begin
						if (hit_pend_q) begin
							res_d.status = ST_PENDING;
							res_d.ip_out = req_q.target_ip;
						end else begin
							res_d.status  = ST_RESOLVED;
							res_d.mac_out = hit_mac_q;
						end
					end else if (!req_q.has_payload || full) begin
						res_d.status = ST_FAILED;
					end else begin
						res_d.status       = ST_QUEUED;
						res_d.ip_out       = req_q.target_ip;
						res_d.send_request = 1'b1;
						mreq.wr_en         = 1'b1;
						mreq.wr_addr       = IDX_W'(used_q);
						mreq.wr_data       = '{ip: req_q.target_ip, mac: 48'd0, pending: 1'b1};
						used_d             = used_q + CNT_W'(1);
					end
				end else if (!hdr_ok) begin
					res_d.status = ST_DROPPED;
				end else begin
					res_d.status = ST_ACCEPTED;
					if (hit_q) begin
						mreq.wr_en         = 1'b1;
						mreq.wr_addr       = hit_idx_q;
						mreq.wr_data       = '{ip: req_q.sender_ip, mac: req_q.sender_mac,
							pending: 1'b0};
						res_d.release_held = hit_pend_q;
					end
					if (req_q.target_ip == local_ip) begin
						if (!hit_q) begin
							if (full) begin
								res_d.status = ST_FULL;
							end else begin
								mreq.wr_en   = 1'b1;
								mreq.wr_addr = IDX_W'(used_q);
								mreq.wr_data = '{ip: req_q.sender_ip, mac: req_q.sender_mac,
									pending: 1'b0};
								used_d       = used_q + CNT_W'(1);
							end
						end
						res_d.send_reply = (req_q.opcode == OP_REQUEST);
					end
					if (res_d.send_reply || res_d.release_held) begin
						res_d.mac_out = req_q.sender_mac;
						res_d.ip_out  = req_q.sender_ip;
					end
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

[rtl/arp_cache_engine_top.sv]
// ----------------------------------------------------------------------------
// arp_cache_engine_top
// ARP cache: resolves addresses and learns from received ARP packets.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  request   start, busy, req                       in (busy out)
//  result    done, result                           out, one cycle strobe
//  config    psel penable pwrite paddr pwdata ...   APB slave
//
// An item is scanned with one table read per cycle, newest entry first,
// ending early on a match; the entry memory has a single read port. Reset
// clears the fill count; the table needs no clearing. Results cannot be
// stalled.
module arp_cache_engine_top
	import arpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	mem_req_t    mreq;
	entry_t      rd_data;
	logic        wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2:0] == 3'd0);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= '0;
			local_mac_q <= '0;
		end else if (wr_hit) begin
			if (paddr[3] == REG_LOCAL_IP) begin
				local_ip_q <= pwdata[31:0];
			end else begin
				local_mac_q <= pwdata[47:0];
			end
		end
	end

	// Return register contents
	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0) begin
			if (paddr[3] == REG_LOCAL_MAC) begin
				prdata = {16'd0, local_mac_q};
			end else begin
				prdata = {32'd0, local_ip_q};
			end
		end
	end

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.local_ip (local_ip_q),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.mreq     (mreq),
		.rd_data  (rd_data)
	);

	arpc_table u_table (
		.clk     (clk),
		.mreq    (mreq),
		.rd_data (rd_data)
	);

endmodule
